@@ hw/rtl/esm_pkg.sv @@
// ---------------------------------------------------------------------------
// esm_pkg
// Shared types, event codes and the deadline table of the event sequence
// monitor.
// ---------------------------------------------------------------------------
package esm_pkg;

  // Result codes reported per event
  typedef enum logic [2:0] {
    RES_OK      = 3'd0,
    RES_LOCKED  = 3'd1,
    RES_UNKNOWN = 3'd2,
    RES_TIME    = 3'd3,
    RES_ORDER   = 3'd4
  } result_e;

  // Known event codes
  localparam logic [15:0] EV_LOAD_START  = 16'd1024;
  localparam logic [15:0] EV_LOAD_STEP1  = 16'd1025;
  localparam logic [15:0] EV_LOAD_STEP2  = 16'd1026;
  localparam logic [15:0] EV_LOAD_STEP3  = 16'd1027;
  localparam logic [15:0] EV_LOAD_STEP4  = 16'd1028;
  localparam logic [15:0] EV_LOAD_DONE   = 16'd1029;
  localparam logic [15:0] EV_LOAD_CLEAR  = 16'd1030;
  localparam logic [15:0] EV_1040        = 16'd1040;
  localparam logic [15:0] EV_EXEMPT      = 16'd1041;
  localparam logic [15:0] EV_1050        = 16'd1050;
  localparam logic [15:0] EV_1051        = 16'd1051;
  localparam logic [15:0] EV_1052        = 16'd1052;
  localparam logic [15:0] EV_FREEZE_ARM  = 16'd1060;
  localparam logic [15:0] EV_FREEZE_USE  = 16'd1061;
  localparam logic [15:0] EV_JOURNAL_ARM = 16'd1070;
  localparam logic [15:0] EV_JOURNAL_USE = 16'd1071;
  localparam logic [15:0] EV_1072        = 16'd1072;

  // Load-chain masks expected before each step
  localparam logic [4:0] LOAD_MASK_1  = 5'd1;
  localparam logic [4:0] LOAD_MASK_3  = 5'd3;
  localparam logic [4:0] LOAD_MASK_7  = 5'd7;
  localparam logic [4:0] LOAD_MASK_15 = 5'd15;
  localparam logic [4:0] LOAD_MASK_31 = 5'd31;

  localparam int unsigned FieldBytesIn = 16;  // 128 payload bits
  localparam int unsigned FieldBytesOut = 2;  // 10 payload bits, padded

  // Ordering state
  typedef struct packed {
    logic [4:0] load_progress;
    logic       freeze_armed;
    logic       journal_armed;
  } ctrl_t;

  // Verdict of one event, from the checker to the state registers
  typedef struct packed {
    result_e code;
    logic    accept;
    ctrl_t   next;
  } verdict_t;

  typedef struct packed {
    logic        known;
    logic [31:0] limit;
  } deadline_t;

  function automatic deadline_t deadline_of(input logic [15:0] code);
    deadline_t d;
    d.known = 1'b1;
    unique case (code)
      EV_LOAD_START:  d.limit = 32'd1;
      EV_LOAD_STEP1:  d.limit = 32'd50;
      EV_LOAD_STEP2:  d.limit = 32'd8000;
      EV_LOAD_STEP3:  d.limit = 32'd10;
      EV_LOAD_STEP4:  d.limit = 32'd2000;
      EV_LOAD_DONE:   d.limit = 32'd10;
      EV_LOAD_CLEAR:  d.limit = 32'd10;
      EV_1040:        d.limit = 32'd100;
      EV_EXEMPT:      d.limit = 32'd30000;
      EV_1050:        d.limit = 32'd1;
      EV_1051:        d.limit = 32'd2000;
      EV_1052:        d.limit = 32'd25000;
      EV_FREEZE_ARM:  d.limit = 32'd1;
      EV_FREEZE_USE:  d.limit = 32'd0;
      EV_JOURNAL_ARM: d.limit = 32'd100;
      EV_JOURNAL_USE: d.limit = 32'd2000;
      EV_1072:        d.limit = 32'd5000;
      default: begin
        d.known = 1'b0;
        d.limit = 32'hFFFF_FFFF;
      end
    endcase
    return d;
  endfunction

endpackage

@@ hw/rtl/esm_ram.sv @@
// ---------------------------------------------------------------------------
// esm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module esm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                            wr_data_i,
  input  logic                                        rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                            rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/esm_eval.sv @@
// ---------------------------------------------------------------------------
// esm_eval
// Single-pass rule check of one event: lock, code lookup, time, deadline
// and ordering, plus the next ordering state.
// ---------------------------------------------------------------------------
module esm_eval (
  input  logic              locked_i,
  input  logic [15:0]       event_code_i,
  input  logic [63:0]       timestamp_ms_i,
  input  logic [31:0]       duration_ms_i,
  input  logic [63:0]       last_time_i,
  input  logic              log_full_i,
  input  esm_pkg::ctrl_t    state_i,
  output esm_pkg::verdict_t verdict_o
);

  esm_pkg::deadline_t dl;
  esm_pkg::ctrl_t     next;
  logic               order_ok;
  logic               late;

  assign dl   = esm_pkg::deadline_of(event_code_i);
  assign late = (dl.limit != 32'd0) && (event_code_i != esm_pkg::EV_EXEMPT)
                && (duration_ms_i > dl.limit);

  // Ordering rules
  always_comb begin
    next     = state_i;
    order_ok = 1'b1;
    unique case (event_code_i)
      esm_pkg::EV_LOAD_START: next.load_progress = esm_pkg::LOAD_MASK_1;
      esm_pkg::EV_LOAD_STEP1: begin
        order_ok           = (state_i.load_progress == esm_pkg::LOAD_MASK_1);
        next.load_progress = esm_pkg::LOAD_MASK_3;
      end
      esm_pkg::EV_LOAD_STEP2: begin
        order_ok           = (state_i.load_progress == esm_pkg::LOAD_MASK_3);
        next.load_progress = esm_pkg::LOAD_MASK_7;
      end
      esm_pkg::EV_LOAD_STEP3: begin
        order_ok           = (state_i.load_progress == esm_pkg::LOAD_MASK_7);
        next.load_progress = esm_pkg::LOAD_MASK_15;
      end
      esm_pkg::EV_LOAD_STEP4: begin
        order_ok           = (state_i.load_progress == esm_pkg::LOAD_MASK_15);
        next.load_progress = esm_pkg::LOAD_MASK_31;
      end
      esm_pkg::EV_LOAD_DONE: begin
        order_ok = (state_i.load_progress == esm_pkg::LOAD_MASK_31);
      end
      esm_pkg::EV_LOAD_CLEAR:  next.load_progress = '0;
      esm_pkg::EV_FREEZE_ARM:  next.freeze_armed = 1'b1;
      esm_pkg::EV_FREEZE_USE:  order_ok = state_i.freeze_armed;
      esm_pkg::EV_JOURNAL_ARM: next.journal_armed = 1'b1;
      esm_pkg::EV_JOURNAL_USE: begin
        order_ok           = state_i.journal_armed;
        next.journal_armed = 1'b0;
      end
      default: ;
    endcase
  end

  // First failing check decides
  always_comb begin
    verdict_o.accept = 1'b0;
    verdict_o.next   = state_i;
    if (locked_i) begin
      verdict_o.code = esm_pkg::RES_LOCKED;
    end else if (!dl.known) begin
      verdict_o.code = esm_pkg::RES_UNKNOWN;
    end else if (log_full_i || (timestamp_ms_i < last_time_i) || late) begin
      verdict_o.code = esm_pkg::RES_TIME;
    end else if (!order_ok) begin
      verdict_o.code = esm_pkg::RES_ORDER;
    end else begin
      verdict_o.code   = esm_pkg::RES_OK;
      verdict_o.accept = 1'b1;
      verdict_o.next   = next;
    end
  end

endmodule

@@ hw/rtl/event_sequence_monitor.sv @@
// ---------------------------------------------------------------------------
// event_sequence_monitor
// Checks timed events against the known-code/deadline table and ordering
// rules, logs accepted events and returns one verdict per event.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid_i/tready_o       event (code, time, dur, status)
//  m_axis    out  m_axis_tvalid_o/tready_i       verdict (result, entry count)
//  cfg       in   cfg_valid_i/cfg_ready_o        locked bit
//
//  One event per cycle sustained unless m_axis stalls; each event passes
//  the input register, then the result register. All checks run in one
//  pass between them, so the ordering state is current for back-to-back events.
//  rst_ni is asynchronous, active low; it clears control state and the
//  entry count. Log contents are not cleared and are never read back.
//  A stalled output holds the result; the input register keeps taking
//  requests as long as the result register can drain.
// ---------------------------------------------------------------------------
module event_sequence_monitor #(
  parameter int unsigned LOG_DEPTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // [15:0] event_code, [79:16] timestamp_ms, [111:80] duration_ms,
  // [127:112] event_status
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,
  // [2:0] result_code, [9:3] entries_logged, [15:10] zero
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [15:0]  m_axis_tdata_o,
  // locked register write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i
);

  localparam int unsigned AddrW  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned CountW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned LogW   = 128;

  // Config register
  logic locked_q;

  // Input register
  logic         in_valid_q;
  logic [127:0] in_data_q;
  logic         advance;

  // Monitor state
  esm_pkg::ctrl_t    ctrl_q;
  logic [CountW-1:0] count_q, count_d;
  logic [63:0]       last_time_q;
  logic              log_full;

  // Result register
  logic       out_valid_q;
  logic [2:0] out_result_q;
  logic [6:0] out_count_q;

  esm_pkg::verdict_t verdict;
  logic [CountW+6:0] count_ext;
  logic [LogW-1:0]   log_entry;

  // Evaluate when an event waits and the result slot is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  assign log_full = (count_q >= CountW'(LOG_DEPTH));

  esm_eval u_eval (
    .locked_i       (locked_q),
    .event_code_i   (in_data_q[15:0]),
    .timestamp_ms_i (in_data_q[79:16]),
    .duration_ms_i  (in_data_q[111:80]),
    .last_time_i    (last_time_q),
    .log_full_i     (log_full),
    .state_i        (ctrl_q),
    .verdict_o      (verdict)
  );

  assign count_d   = verdict.accept ? count_q + CountW'(1) : count_q;
  assign count_ext = {7'd0, count_d};

  // Log layout: time, duration, status, code (code in the low bits)
  assign log_entry = {in_data_q[79:16], in_data_q[111:80],
                      in_data_q[127:112], in_data_q[15:0]};

  esm_ram #(
    .WIDTH (LogW),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk_i     (clk_i),
    .wr_en_i   (advance && verdict.accept),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i (log_entry),
    .rd_en_i   (1'b0),
    .rd_addr_i ('0),
    .rd_data_o ()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0;
    end else if (cfg_valid_i) begin
      locked_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  // State moves only on an accepted event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      count_q     <= '0;
      last_time_q <= '0;
    end else if (advance && verdict.accept) begin
      ctrl_q      <= verdict.next;
      count_q     <= count_d;
      last_time_q <= in_data_q[79:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= verdict.code;
      out_count_q  <= count_ext[6:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_count_q, out_result_q};

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stream-level test of the event sequence monitor. Events are pushed through
// the s_axis side with random gaps, verdicts are drained from m_axis with
// random back-pressure. A scoreboard predicts every verdict from its own
// model of the code table, deadlines, load chain, arm flags, log fill and
// the lock bit, and checks each verdict in order.
// ---------------------------------------------------------------------------
import esm_pkg::*;

// One predicted verdict
typedef struct {
  result_e    code;
  logic [6:0] entries;
} verdict_exp_t;

class verdict_scoreboard;
  // predicted block state
  bit           locked;
  logic [4:0]   load_progress;
  bit           freeze_armed;
  bit           journal_armed;
  int unsigned  entry_count;
  logic [63:0]  last_time;
  int unsigned  log_depth;
  verdict_exp_t pending[$];
  int unsigned  mismatches;

  function new(int unsigned depth);
    log_depth     = depth;
    locked        = 1'b0;
    load_progress = '0;
    freeze_armed  = 1'b0;
    journal_armed = 1'b0;
    entry_count   = 0;
    last_time     = '0;
    mismatches    = 0;
  endfunction

  // Deadline in ms; -1 marks a code outside the table
  function longint time_limit(logic [15:0] code);
    case (code)
      EV_LOAD_START, EV_1050, EV_FREEZE_ARM:       return 1;
      EV_LOAD_STEP3, EV_LOAD_DONE, EV_LOAD_CLEAR:  return 10;
      EV_LOAD_STEP1:                               return 50;
      EV_1040, EV_JOURNAL_ARM:                     return 100;
      EV_LOAD_STEP4, EV_1051, EV_JOURNAL_USE:      return 2000;
      EV_1072:                                     return 5000;
      EV_LOAD_STEP2:                               return 8000;
      EV_1052:                                     return 25000;
      EV_EXEMPT:                                   return 30000;
      EV_FREEZE_USE:                               return 0;
      default:                                     return -1;
    endcase
  endfunction

  // True when the ordering rules refuse this code in the present state
  function bit order_blocked(logic [15:0] code);
    case (code)
      EV_LOAD_STEP1:  return load_progress != LOAD_MASK_1;
      EV_LOAD_STEP2:  return load_progress != LOAD_MASK_3;
      EV_LOAD_STEP3:  return load_progress != LOAD_MASK_7;
      EV_LOAD_STEP4:  return load_progress != LOAD_MASK_15;
      EV_LOAD_DONE:   return load_progress != LOAD_MASK_31;
      EV_FREEZE_USE:  return !freeze_armed;
      EV_JOURNAL_USE: return !journal_armed;
      default:        return 1'b0;
    endcase
  endfunction

  // Accepted event request: judge it and queue the verdict
  function void note_event(logic [15:0] code, logic [63:0] stamp, logic [31:0] dur);
    verdict_exp_t v;
    longint       lim;
    lim = time_limit(code);
    if (locked) v.code = RES_LOCKED;
    else if (lim < 0) v.code = RES_UNKNOWN;
    else if (entry_count >= log_depth || stamp < last_time) v.code = RES_TIME;
    else if (lim != 0 && code != EV_EXEMPT && longint'(dur) > lim) v.code = RES_TIME;
    else if (order_blocked(code)) v.code = RES_ORDER;
    else begin
      v.code = RES_OK;
      case (code)
        EV_LOAD_START:  load_progress = LOAD_MASK_1;
        EV_LOAD_STEP1:  load_progress[1] = 1'b1;
        EV_LOAD_STEP2:  load_progress[2] = 1'b1;
        EV_LOAD_STEP3:  load_progress[3] = 1'b1;
        EV_LOAD_STEP4:  load_progress[4] = 1'b1;
        EV_LOAD_CLEAR:  load_progress = '0;
        EV_FREEZE_ARM:  freeze_armed = 1'b1;
        EV_JOURNAL_ARM: journal_armed = 1'b1;
        EV_JOURNAL_USE: journal_armed = 1'b0;
        default: ;
      endcase
      entry_count++;
      last_time = stamp;
    end
    v.entries = 7'(entry_count);
    pending.push_back(v);
  endfunction

  function void flag(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  // Verdict request seen on m_axis
  function void check_verdict(logic [15:0] tdata);
    verdict_exp_t v;
    if (pending.size() == 0) begin
      flag("verdict with nothing pending, tdata", 0, tdata);
      return;
    end
    v = pending.pop_front();
    if (tdata[2:0] !== v.code) flag("result_code", v.code, tdata[2:0]);
    if (tdata[9:3] !== v.entries) flag("entries_logged", v.entries, tdata[9:3]);
  endfunction

  function int unsigned outstanding();
    return pending.size();
  endfunction
endclass

module tb_top;

  localparam int unsigned LOG_DEPTH   = 64;
  localparam int unsigned STALL_LIMIT = 1000;  // cycles with no handshake at all
  localparam int unsigned IDLE_PCT    = 38;

  localparam logic [15:0] KNOWN_EVENTS [17] = '{
    EV_LOAD_START, EV_LOAD_STEP1, EV_LOAD_STEP2, EV_LOAD_STEP3, EV_LOAD_STEP4,
    EV_LOAD_DONE, EV_LOAD_CLEAR, EV_1040, EV_EXEMPT, EV_1050, EV_1051, EV_1052,
    EV_FREEZE_ARM, EV_FREEZE_USE, EV_JOURNAL_ARM, EV_JOURNAL_USE, EV_1072
  };
  // codes the ordering rules can refuse
  localparam logic [15:0] GUARDED_EVENTS [7] = '{
    EV_LOAD_STEP1, EV_LOAD_STEP2, EV_LOAD_STEP3, EV_LOAD_STEP4, EV_LOAD_DONE,
    EV_FREEZE_USE, EV_JOURNAL_USE
  };
  // codes with no ordering rule
  localparam logic [15:0] PLAIN_EVENTS [6] = '{
    EV_1040, EV_EXEMPT, EV_1050, EV_1051, EV_1052, EV_1072
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // [15:0] event_code, [79:16] timestamp_ms, [111:80] duration_ms,
  // [127:112] event_status
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // [2:0] result_code, [9:3] entries_logged, [15:10] zero
  logic [15:0]  m_axis_tdata_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_data_i = 1'b0;

  bit           calm = 1'b0;  // no idling on either side while set
  int unsigned  quiet_cycles = 0;

  verdict_scoreboard sb = new(LOG_DEPTH);

  event_sequence_monitor #(
    .LOG_DEPTH(LOG_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Verdict sink: check at the edge, then pick next cycle's back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_verdict(m_axis_tdata_o);
    m_axis_tready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: a handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Duration that passes the deadline check of this code
  function automatic logic [31:0] dur_within(logic [15:0] code);
    longint lim;
    lim = sb.time_limit(code);
    // exempt event and zero deadline: anything goes
    if (lim == 0 || code == EV_EXEMPT) return $urandom;
    case ($urandom_range(2))
      0:       return '0;
      1:       return 32'(lim);
      default: return $urandom_range(32'(lim), 0);
    endcase
  endfunction

  // Drive one event request and wait for it to be taken
  task automatic push_event(input logic [15:0] code, input logic [63:0] stamp,
                            input logic [31:0] dur, input logic [15:0] status);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {status, dur, stamp, code};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_event(code, stamp, dur);
  endtask

  // Lock bit write; only once the monitor has drained
  task automatic set_lock(input bit value);
    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);  // two-stage pipe, plus margin
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.locked = value;
  endtask

  // One random event. Mix: unknown codes, backwards time, missed deadlines,
  // well-formed steps (accept_pct of them), rest are out-of-order steps
  // with clean time and duration so the order check itself is hit.
  task automatic random_event(input int unsigned accept_pct);
    logic [15:0] code;
    logic [63:0] stamp;
    logic [31:0] dur;
    longint      lim;
    int unsigned pick;
    pick  = $urandom_range(99);
    stamp = sb.last_time + 64'($urandom_range(400));
    if (pick < 8) begin
      // half right around the table, half anywhere; all fields full width
      do begin
        if ($urandom_range(1) != 0) code = 16'($urandom);
        else code = 16'($urandom_range(EV_1072 + 8, EV_LOAD_START - 8));
      end while (sb.time_limit(code) >= 0);
      stamp = {$urandom, $urandom};
      dur   = $urandom;
    end else if (pick < 16 && sb.last_time != 0) begin
      code  = KNOWN_EVENTS[$urandom_range(16)];
      stamp = {$urandom, $urandom} % sb.last_time;
      dur   = dur_within(code);
    end else if (pick < 28) begin
      do code = KNOWN_EVENTS[$urandom_range(16)];
      while (sb.time_limit(code) == 0 || code == EV_EXEMPT);
      lim = sb.time_limit(code);
      if ($urandom_range(2) == 0) dur = 32'(lim) + 1;
      else dur = $urandom_range(32'hFFFF_FFFF, 32'(lim) + 1);
    end else if (pick < 28 + accept_pct) begin
      case ($urandom_range(3))
        0, 1: begin
          case (sb.load_progress)
            '0:           code = EV_LOAD_START;
            LOAD_MASK_1:  code = EV_LOAD_STEP1;
            LOAD_MASK_3:  code = EV_LOAD_STEP2;
            LOAD_MASK_7:  code = EV_LOAD_STEP3;
            LOAD_MASK_15: code = EV_LOAD_STEP4;
            LOAD_MASK_31: code = ($urandom_range(1) != 0) ? EV_LOAD_DONE : EV_LOAD_CLEAR;
            default:      code = EV_LOAD_CLEAR;
          endcase
        end
        2: begin
          if (sb.freeze_armed && $urandom_range(1) != 0) code = EV_FREEZE_USE;
          else if (sb.journal_armed && $urandom_range(1) != 0) code = EV_JOURNAL_USE;
          else code = ($urandom_range(1) != 0) ? EV_FREEZE_ARM : EV_JOURNAL_ARM;
        end
        default: code = PLAIN_EVENTS[$urandom_range(5)];
      endcase
      dur = dur_within(code);
      // the entry that fills the log carries the largest timestamp
      if (sb.entry_count == LOG_DEPTH - 1) stamp = '1;
    end else begin
      do code = GUARDED_EVENTS[$urandom_range(6)]; while (!sb.order_blocked(code));
      dur = dur_within(code);
    end
    push_event(code, stamp, dur, 16'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_lock(1'b0);

    // Directed: table edges, every ordering rule, time corner cases
    push_event(16'h0000, '0, '0, 16'h0000);                     // unknown, lowest code
    push_event(16'hFFFF, '1, '1, 16'hFFFF);                     // unknown, all ones
    push_event(EV_LOAD_START - 1, 64'd1, 32'd0, 16'($urandom)); // just below table
    push_event(EV_1072 + 1, 64'd1, 32'd0, 16'($urandom));       // just above table
    push_event(EV_LOAD_STEP1, 64'd10, 32'd0, 16'($urandom));    // chain not started
    push_event(EV_FREEZE_USE, 64'd10, '1, 16'($urandom));       // not armed
    push_event(EV_JOURNAL_USE, 64'd10, 32'd0, 16'($urandom));   // not armed
    push_event(EV_LOAD_START, 64'd100, 32'd2, 16'($urandom));   // one over deadline
    push_event(EV_LOAD_START, 64'd100, 32'd1, 16'($urandom));   // exactly on deadline
    push_event(EV_LOAD_STEP1, 64'd100, 32'd50, 16'($urandom));  // same timestamp
    push_event(EV_LOAD_STEP3, 64'd101, 32'd0, 16'($urandom));   // skipped a step
    push_event(EV_LOAD_STEP2, 64'd101, 32'd8000, 16'($urandom));
    push_event(EV_LOAD_STEP3, 64'd102, 32'd10, 16'($urandom));
    push_event(EV_LOAD_STEP4, 64'd103, 32'd2000, 16'($urandom));
    push_event(EV_LOAD_DONE, 64'd104, 32'd10, 16'($urandom));
    push_event(EV_LOAD_DONE, 64'd104, 32'd0, 16'($urandom));    // mask stays full
    push_event(EV_1040, 64'd50, 32'd0, 16'($urandom));          // time going backwards
    push_event(EV_LOAD_CLEAR, 64'd105, 32'd10, 16'($urandom));
    push_event(EV_LOAD_STEP1, 64'd106, 32'd0, 16'($urandom));   // chain cleared
    push_event(EV_EXEMPT, 64'd107, '1, 16'($urandom));          // exempt from deadline
    push_event(EV_FREEZE_ARM, 64'd108, 32'd1, 16'($urandom));
    push_event(EV_FREEZE_USE, 64'd108, '1, 16'($urandom));      // zero deadline
    push_event(EV_FREEZE_USE, 64'd109, 32'd0, 16'($urandom));   // flag stays armed
    push_event(EV_JOURNAL_ARM, 64'd110, 32'd100, 16'($urandom));
    push_event(EV_JOURNAL_USE, 64'd111, 32'd2000, 16'($urandom));
    push_event(EV_JOURNAL_USE, 64'd112, 32'd0, 16'($urandom));  // consumed already

    set_lock(1'b1);
    repeat (150) random_event(0);

    // Main unlocked run, accepts kept sparse so the log fills late
    set_lock(1'b0);
    for (int i = 0; i < 1400; i++) begin
      calm = (i >= 300 && i < 600);
      random_event(4);
    end
    calm = 1'b0;

    set_lock(1'b1);
    repeat (100) random_event(0);

    // Unlocked again; any room left in the log gets used up
    set_lock(1'b0);
    repeat (200) random_event(30);

    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ event_sequence_monitor.f @@
hw/rtl/esm_pkg.sv
hw/rtl/esm_ram.sv
hw/rtl/esm_eval.sv
hw/rtl/event_sequence_monitor.sv
tb/tb_top.sv
